@@ design/bcpe_pkg.sv @@
// Shared types and constants for the Bezier point evaluator.
// No dependencies; used by every module of the block.
`default_nettype none

package bcpe_pkg;

  // Field widths
  localparam int POINT_W     = 32;
  localparam int HALF_W      = POINT_W / 2;
  localparam int TAU_W       = 18;
  localparam int GAIN_W      = 17;
  localparam int TAU_FRAC    = 16;
  localparam int COORD_WIDTH = 32;

  // Parameter and weight arithmetic
  localparam int T_W    = TAU_FRAC + 1;
  localparam int PROD_W = TAU_W + GAIN_W + 1;
  localparam int SQ_W   = 2 * TAU_FRAC + 1;
  localparam int WSH    = 3 * TAU_FRAC;
  localparam int W_W    = WSH + 1;

  localparam int TAU_ONE  = 1 << TAU_FRAC;
  localparam int TAU_HALF = 1 << (TAU_FRAC - 1);

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(TAU_ONE);

  localparam logic [W_W-1:0] W_ONE  = W_W'(1) << WSH;
  localparam logic [W_W-1:0] W_HALF = W_ONE >> 1;

  // Accumulation widths
  localparam int HP_W  = HALF_W + W_W + 1;
  localparam int LP_W  = HALF_W + W_W;
  localparam int HS_W  = HP_W + 2;
  localparam int LS_W  = LP_W + 2;
  localparam int SUM_W = HS_W + HALF_W + 1;
  localparam int RES_W = SUM_W - WSH;

  localparam longint LIM_HI = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint LIM_LO = -LIM_HI - 1;

  typedef enum logic {
    OP_QUAD  = 1'b0,
    OP_CUBIC = 1'b1
  } op_t;

  typedef logic [3:0][POINT_W-1:0] points_t;

  typedef struct packed {
    op_t     op;
    points_t pts;
  } item_t;

  // Parameter stage result: clamped tau, its complement and their products
  typedef struct packed {
    logic            valid;
    item_t           item;
    logic [T_W-1:0]  t;
    logic [T_W-1:0]  u;
    logic [SQ_W-1:0] uu;
    logic [SQ_W-1:0] ut;
    logic [SQ_W-1:0] tt;
  } param_t;

  // Weight stage result: four Bernstein weights scaled to 2^48
  typedef struct packed {
    logic                valid;
    item_t               item;
    logic [3:0][W_W-1:0] w;
  } weight_t;

endpackage

`default_nettype wire

@@ design/bezier_curve_point_eval.sv @@
// Channel   Handshake                    Payload
// request   start / busy                 op, tau, point0..point3
// result    done (one-cycle strobe)      coordinate
// config    tau_gain_valid / _ready      tau_gain
//
// Fully pipelined: a request can be taken every cycle; its result strobes
// on done once it has passed the register stages (3 parameter, 2 weight, 3 sum).
// The depth follows the chain of multipliers and the round, select and sum steps between them.
// Synchronous reset empties the pipeline and sets tau_gain to 1.0; busy rises
// and tau_gain_ready drops only while reset is held. Results cannot be stalled.
//
// Top level of the Bezier point evaluator; depends on bcpe_pkg, bcpe_param,
// bcpe_weight and bcpe_mac.
`default_nettype none

module bezier_curve_point_eval import bcpe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      op,
  input  logic signed [TAU_W-1:0]   tau,
  input  logic signed [POINT_W-1:0] point0,
  input  logic signed [POINT_W-1:0] point1,
  input  logic signed [POINT_W-1:0] point2,
  input  logic signed [POINT_W-1:0] point3,
  input  logic                      tau_gain_valid,
  output logic                      tau_gain_ready,
  input  logic [GAIN_W-1:0]         tau_gain,
  output logic                      done,
  output logic signed [POINT_W-1:0] coordinate
);

  localparam int LATENCY = 8;

  logic              accept;
  logic [GAIN_W-1:0] gain;
  item_t             in_item;
  param_t            prm;
  weight_t           wgt;

  assign busy           = rst;
  assign tau_gain_ready = !rst;
  assign accept         = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (tau_gain_valid && tau_gain_ready) begin
      gain <= tau_gain;
    end
  end

  always_comb begin
    in_item.op  = op_t'(op);
    in_item.pts = {point3, point2, point1, point0};
  end

  bcpe_param u_param (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .in_item  (in_item),
    .in_tau   (tau),
    .gain     (gain),
    .out      (prm)
  );

  bcpe_weight u_weight (
    .clk (clk),
    .rst (rst),
    .in  (prm),
    .out (wgt)
  );

  bcpe_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .in         (wgt),
    .valid      (done),
    .coordinate (coordinate)
  );

`ifndef SYNTHESIS
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching request");

  a_request_completes: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted request produced no result");
`endif

endmodule

`default_nettype wire

@@ design/bcpe_param.sv @@
// Tau gain, round-and-clamp, and the second-order products of t and u.
// Three register stages; depends on bcpe_pkg.
`default_nettype none

module bcpe_param import bcpe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  item_t                   in_item,
  input  logic signed [TAU_W-1:0] in_tau,
  input  logic [GAIN_W-1:0]       gain,
  output param_t                  out
);

  // Stage A: gain product
  logic                     a_valid;
  item_t                    a_item;
  logic signed [PROD_W-1:0] a_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_item <= in_item;
    a_prod <= in_tau * $signed({1'b0, gain});
  end

  // Stage B: round to Q.16 and clamp to [0,1]
  logic [PROD_W-1:0]          rnd;
  logic [PROD_W-TAU_FRAC-1:0] t_raw;
  logic [T_W-1:0]             t_next;

  always_comb begin
    rnd   = a_prod + PROD_W'(TAU_HALF);
    t_raw = rnd[PROD_W-1:TAU_FRAC];
    if (a_prod[PROD_W-1] || a_prod == '0) begin
      t_next = '0;
    end else if (t_raw > (PROD_W-TAU_FRAC)'(TAU_ONE)) begin
      t_next = T_W'(TAU_ONE);
    end else begin
      t_next = t_raw[T_W-1:0];
    end
  end

  logic           b_valid;
  item_t          b_item;
  logic [T_W-1:0] b_t;
  logic [T_W-1:0] b_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_item <= a_item;
    b_t    <= t_next;
    b_u    <= T_W'(TAU_ONE) - t_next;
  end

  // Stage C: squares and cross product
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= b_valid;
    end
    out.item <= b_item;
    out.t    <= b_t;
    out.u    <= b_u;
    out.uu   <= b_u * b_u;
    out.ut   <= b_u * b_t;
    out.tt   <= b_t * b_t;
  end

`ifndef SYNTHESIS
  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_t <= T_W'(TAU_ONE)) && ({1'b0, b_t} + {1'b0, b_u} == (T_W+1)'(TAU_ONE)))
    else $error("clamped tau and its complement do not add to one");
`endif

endmodule

`default_nettype wire

@@ design/bcpe_weight.sv @@
// Bernstein weights for quadratic or cubic curves, scaled to 2^48.
// Two register stages; depends on bcpe_pkg.
`default_nettype none

module bcpe_weight import bcpe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  param_t  in,
  output weight_t out
);

  // Stage D: third-order products
  logic                d_valid;
  item_t               d_item;
  logic [3:0][W_W-1:0] d_c;
  logic [SQ_W-1:0]     d_uu;
  logic [SQ_W-1:0]     d_ut;
  logic [SQ_W-1:0]     d_tt;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= in.valid;
    end
    d_item <= in.item;
    d_c[0] <= in.uu * in.u;
    d_c[1] <= in.ut * in.u;
    d_c[2] <= in.ut * in.t;
    d_c[3] <= in.tt * in.t;
    d_uu   <= in.uu;
    d_ut   <= in.ut;
    d_tt   <= in.tt;
  end

  // Stage E: pick weights by curve order
  logic [3:0][W_W-1:0] w_next;

  always_comb begin
    case (d_item.op)
      OP_CUBIC: begin
        w_next[0] = d_c[0];
        w_next[1] = d_c[1] + {d_c[1][W_W-2:0], 1'b0};
        w_next[2] = d_c[2] + {d_c[2][W_W-2:0], 1'b0};
        w_next[3] = d_c[3];
      end
      OP_QUAD: begin
        w_next[0] = {d_uu, {TAU_FRAC{1'b0}}};
        w_next[1] = {d_ut[SQ_W-2:0], {(TAU_FRAC+1){1'b0}}};
        w_next[2] = {d_tt, {TAU_FRAC{1'b0}}};
        w_next[3] = '0;
      end
      default: begin
        w_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= d_valid;
    end
    out.item <= d_item;
    out.w    <= w_next;
  end

`ifndef SYNTHESIS
  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> (out.w[0] + out.w[1] + out.w[2] + out.w[3] == W_ONE))
    else $error("Bernstein weights do not sum to one");
`endif

endmodule

`default_nettype wire

@@ design/bcpe_mac.sv @@
// Weighted sum of the control points, round half up, saturate.
// Three register stages; depends on bcpe_pkg.
`default_nettype none

module bcpe_mac import bcpe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  weight_t                   in,
  output logic                      valid,
  output logic signed [POINT_W-1:0] coordinate
);

  // Stage F: each point split into signed high half and unsigned low half
  logic                   f_valid;
  logic signed [HP_W-1:0] f_hp [4];
  logic [LP_W-1:0]        f_lp [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= in.valid;
    end
    for (int i = 0; i < 4; i++) begin
      f_hp[i] <= $signed(in.item.pts[i][POINT_W-1:HALF_W]) * $signed({1'b0, in.w[i]});
      f_lp[i] <= in.item.pts[i][HALF_W-1:0] * in.w[i];
    end
  end

  // Stage G: lane sums
  logic signed [HS_W-1:0] hs_next;
  logic [LS_W-1:0]        ls_next;

  always_comb begin
    hs_next = '0;
    ls_next = '0;
    for (int i = 0; i < 4; i++) begin
      hs_next = hs_next + HS_W'(f_hp[i]);
      ls_next = ls_next + LS_W'(f_lp[i]);
    end
  end

  logic                   g_valid;
  logic signed [HS_W-1:0] g_hs;
  logic [LS_W-1:0]        g_ls;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else begin
      g_valid <= f_valid;
    end
    g_hs <= hs_next;
    g_ls <= ls_next;
  end

  // Stage H: merge halves, round half up, saturate
  logic signed [SUM_W-1:0] s_full;
  logic signed [RES_W-1:0] res;
  logic signed [RES_W-1:0] sat;

  always_comb begin
    s_full = (SUM_W'(g_hs) <<< HALF_W) + SUM_W'(g_ls) + SUM_W'(W_HALF);
    res    = s_full[SUM_W-1:WSH];
    if (64'(res) > LIM_HI) begin
      sat = RES_W'(LIM_HI);
    end else if (64'(res) < LIM_LO) begin
      sat = RES_W'(LIM_LO);
    end else begin
      sat = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= g_valid;
    end
    coordinate <= sat[POINT_W-1:0];
  end

endmodule

`default_nettype wire

@@ sim/bcpe_checker.sv @@
// Checker for the Bezier point evaluator: watches the request, result and gain channels,
// predicts each coordinate and compares it with the one the block returns.
// Depends on bcpe_pkg; instantiated by tb_bezier_curve_point_eval.

module bcpe_checker import bcpe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      op,
  input  logic signed [TAU_W-1:0]   tau,
  input  logic signed [POINT_W-1:0] point0,
  input  logic signed [POINT_W-1:0] point1,
  input  logic signed [POINT_W-1:0] point2,
  input  logic signed [POINT_W-1:0] point3,
  input  logic                      tau_gain_valid,
  input  logic                      tau_gain_ready,
  input  logic [GAIN_W-1:0]         tau_gain,
  input  logic                      done,
  input  logic signed [POINT_W-1:0] coordinate,
  output int                        fail_count,
  output int                        pending
);

  logic [GAIN_W-1:0]         gain_copy;
  logic signed [POINT_W-1:0] coord_expected[$];

  // Clamp the scaled tau, form the Bernstein weights at 2^48 and round the exact sum.
  function automatic logic signed [POINT_W-1:0] bezier_coordinate(
    op_t order, logic signed [TAU_W-1:0] tau_in, logic [GAIN_W-1:0] gain, points_t pts);
    longint            scaled;
    longint            t_round;
    logic [T_W-1:0]    t;
    logic [T_W-1:0]    u;
    logic [W_W-1:0]    w [4];
    logic signed [95:0] acc;
    logic signed [95:0] pw;
    logic signed [95:0] ww;
    logic signed [95:0] res;
    scaled = longint'(tau_in) * longint'(gain);
    if (scaled <= 0) begin
      t = '0;
    end else begin
      t_round = (scaled + TAU_HALF) >>> TAU_FRAC;
      t = (t_round > TAU_ONE) ? T_W'(TAU_ONE) : T_W'(t_round);
    end
    u = T_W'(TAU_ONE) - t;
    case (order)
      OP_CUBIC: begin
        w[0] = W_W'(u) * u * u;
        w[1] = W_W'(3) * u * u * t;
        w[2] = W_W'(3) * u * t * t;
        w[3] = W_W'(t) * t * t;
      end
      default: begin
        w[0] = (W_W'(u) * u) << TAU_FRAC;
        w[1] = (W_W'(2) * u * t) << TAU_FRAC;
        w[2] = (W_W'(t) * t) << TAU_FRAC;
        w[3] = '0;
      end
    endcase
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      pw = $signed(pts[i]);
      ww = w[i];
      acc = acc + pw * ww;
    end
    // round half up, then floor
    res = (acc + (96'sd1 <<< (WSH - 1))) >>> WSH;
    if (res > LIM_HI) res = LIM_HI;
    if (res < LIM_LO) res = LIM_LO;
    return res[POINT_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [POINT_W-1:0] want;
    if (rst) begin
      gain_copy = GAIN_RESET;
      coord_expected.delete();
      pending <= 0;
    end else begin
      if (done) begin
        if (coord_expected.size() == 0) begin
          $error("coordinate: no result expected, got %0d", coordinate);
          fail_count <= fail_count + 1;
        end else begin
          want = coord_expected.pop_front();
          if (coordinate !== want) begin
            $error("coordinate: expected %0d, actual %0d", want, coordinate);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        coord_expected.push_back(bezier_coordinate(op_t'(op), tau, gain_copy,
                                                   {point3, point2, point1, point0}));
      if (tau_gain_valid && tau_gain_ready)
        gain_copy = tau_gain;
      pending <= coord_expected.size();
    end
  end

endmodule

@@ sim/tb_bezier_curve_point_eval.sv @@
// Testbench top for bezier_curve_point_eval: drives directed and random requests
// under several tau_gain settings and idle patterns, and reports the verdict.
// Depends on bcpe_pkg, the block and bcpe_checker.

module tb_bezier_curve_point_eval;
  import bcpe_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS = 150;

  localparam logic signed [POINT_W-1:0] P_MAX = 32'sh7fffffff;
  localparam logic signed [POINT_W-1:0] P_MIN = 32'sh80000000;
  localparam logic signed [TAU_W-1:0]   TAU_MAX = 18'sh1ffff;
  localparam logic signed [TAU_W-1:0]   TAU_MIN = 18'sh20000;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      op;
  logic signed [TAU_W-1:0]   tau;
  logic signed [POINT_W-1:0] point0;
  logic signed [POINT_W-1:0] point1;
  logic signed [POINT_W-1:0] point2;
  logic signed [POINT_W-1:0] point3;
  logic                      tau_gain_valid;
  logic                      tau_gain_ready;
  logic [GAIN_W-1:0]         tau_gain;
  logic                      done;
  logic signed [POINT_W-1:0] coordinate;
  int                        fail_count;
  int                        pending;
  int                        cycles;

  bezier_curve_point_eval dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .tau(tau),
    .point0(point0), .point1(point1), .point2(point2), .point3(point3),
    .tau_gain_valid(tau_gain_valid), .tau_gain_ready(tau_gain_ready),
    .tau_gain(tau_gain), .done(done), .coordinate(coordinate)
  );

  bcpe_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .tau(tau),
    .point0(point0), .point1(point1), .point2(point2), .point3(point3),
    .tau_gain_valid(tau_gain_valid), .tau_gain_ready(tau_gain_ready),
    .tau_gain(tau_gain), .done(done), .coordinate(coordinate),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Hold start high until the request is taken; the caller lowers it when idling.
  task automatic issue_request(op_t order, logic signed [TAU_W-1:0] t_in,
                               logic signed [POINT_W-1:0] p0, logic signed [POINT_W-1:0] p1,
                               logic signed [POINT_W-1:0] p2, logic signed [POINT_W-1:0] p3);
    @(negedge clk);
    start = 1'b1;
    op = order;
    tau = t_in;
    point0 = p0;
    point1 = p1;
    point2 = p2;
    point3 = p3;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic stay_idle(int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // Drain the pipeline, then write the gain register.
  task automatic write_gain(logic [GAIN_W-1:0] gain);
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    tau_gain_valid = 1'b1;
    tau_gain = gain;
    @(posedge clk);
    while (!tau_gain_ready) @(posedge clk);
    @(negedge clk);
    tau_gain_valid = 1'b0;
  endtask

  function automatic logic signed [POINT_W-1:0] pick_point();
    case ($urandom_range(7))
      0: return P_MAX;
      1: return P_MIN;
      2: return POINT_W'(int'($urandom_range(1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    logic signed [TAU_W-1:0] t_in;
    case ($urandom_range(9))
      6: t_in = TAU_W'($urandom);
      7: t_in = -TAU_W'($urandom_range(1, 131072));
      8: t_in = TAU_W'($urandom_range(65536, 131071));
      9: case ($urandom_range(5))
           0: t_in = '0;
           1: t_in = 1;
           2: t_in = 65535;
           3: t_in = 65536;
           4: t_in = 65537;
           default: t_in = -1;
         endcase
      default: t_in = TAU_W'($urandom_range(65536));
    endcase
    issue_request(op_t'($urandom_range(1)), t_in,
                  pick_point(), pick_point(), pick_point(), pick_point());
  endtask

  initial begin
    int                unsigned gain_plan [6];
    int                idle_plan [6];
    int                burst_pct;
    logic [GAIN_W-1:0] gain;
    gain_plan = '{72090, 0, 131071, 0, 1, 65536};
    idle_plan = '{0, 77, 30, 77, 0, 30};
    rst = 1'b1;
    start = 1'b0;
    op = 1'b0;
    tau = '0;
    point0 = '0;
    point1 = '0;
    point2 = '0;
    point3 = '0;
    tau_gain_valid = 1'b0;
    tau_gain = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests at the reset gain of 1.0
    issue_request(OP_QUAD,  0,       32'h10000, 32'h20000, 32'h30000, 32'h40000);
    issue_request(OP_QUAD,  65536,   32'h10000, 32'h20000, 32'h30000, 32'h40000);
    issue_request(OP_CUBIC, 65536,   32'h10000, 32'h20000, 32'h30000, 32'h40000);
    issue_request(OP_CUBIC, 0,       32'h10000, 32'h20000, 32'h30000, 32'h40000);
    issue_request(OP_CUBIC, TAU_MIN, P_MAX, P_MIN, P_MAX, P_MIN);
    issue_request(OP_CUBIC, TAU_MAX, P_MAX, P_MIN, P_MAX, P_MIN);
    issue_request(OP_QUAD,  32768,   P_MAX, P_MAX, P_MAX, P_MAX);
    issue_request(OP_CUBIC, 32768,   P_MIN, P_MIN, P_MIN, P_MIN);
    issue_request(OP_CUBIC, 21845,   P_MIN, P_MAX, P_MIN, P_MAX);
    issue_request(OP_QUAD,  1,       P_MAX, P_MIN, P_MAX, P_MIN);
    issue_request(OP_QUAD,  65535,   P_MIN, P_MAX, P_MIN, P_MAX);
    // point3 must not matter in quadratic mode
    issue_request(OP_QUAD,  40000,   32'h12345678, -32'sh0abcdef0, 32'h7654321, P_MAX);
    issue_request(OP_QUAD,  40000,   32'h12345678, -32'sh0abcdef0, 32'h7654321, P_MIN);
    issue_request(OP_CUBIC, -1,      32'h1, 32'h2, 32'h3, 32'h4);
    issue_request(OP_CUBIC, 12345,   '0, '0, '0, '0);
    // exact half results: +1/2 rounds up, -1/2 rounds to zero
    issue_request(OP_QUAD,  32768,   '0, 1, '0, '0);
    issue_request(OP_QUAD,  32768,   '0, -1, '0, '0);

    // Gain of 1.5: scaled tau rounds half up, overshoot clamps to 1.0
    write_gain(98304);
    issue_request(OP_CUBIC, 1,       P_MIN, P_MAX, P_MIN, P_MAX);
    issue_request(OP_QUAD,  -1,      P_MAX, P_MIN, P_MAX, P_MIN);
    issue_request(OP_CUBIC, 65536,   32'h10000, 32'h20000, 32'h30000, 32'h40000);
    issue_request(OP_QUAD,  43690,   32'h10000, -32'sh20000, 32'h30000, '0);

    for (int ph = 0; ph < 6; ph++) begin
      gain = (ph == 3) ? GAIN_W'($urandom_range(131071)) : GAIN_W'(gain_plan[ph]);
      write_gain(gain);
      burst_pct = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // leave some stretches free of gaps
        if (n % 30 == 0)
          burst_pct = ($urandom_range(3) == 0) ? 0 : idle_plan[ph];
        stay_idle(burst_pct);
        random_request();
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
